>>> rtl/isfp_pkg.sv
`default_nettype none

package isfp_pkg;

    // Result kind codes carried on tuser
    typedef enum logic [1:0] {
        KIND_GYRO  = 2'd0,
        KIND_ACCEL = 2'd1,
        KIND_EULER = 2'd2,
        KIND_MAG   = 2'd3
    } kind_t;

    // Configuration register indexes
    localparam logic [2:0] REG_HEADER = 3'd0;
    localparam logic [2:0] REG_ACCEL  = 3'd1;
    localparam logic [2:0] REG_GYRO   = 3'd2;
    localparam logic [2:0] REG_EULER  = 3'd3;
    localparam logic [2:0] REG_MAG    = 3'd4;

    localparam logic [7:0] HEADER_RST = 8'h55;
    localparam logic [7:0] ACCEL_RST  = 8'h51;
    localparam logic [7:0] GYRO_RST   = 8'h52;
    localparam logic [7:0] EULER_RST  = 8'h53;
    localparam logic [7:0] MAG_RST    = 8'h54;

    // Lowest legal kind byte
    localparam logic [7:0] KIND_MIN = 8'h50;

    // Field widths
    localparam int AXIS_W = 24;
    localparam int TEMP_W = 18;
    localparam int OUT_TDATA_W = 96;

    // Temperature = floor(w3 * 64 / 25): bias so the dividend stays
    // non-negative, divide by reciprocal multiply, remove the bias.
    localparam logic [17:0] TEMP_BIAS_Q   = 18'd83887;       // bias / 25
    localparam logic [22:0] TEMP_BIAS     = 23'd2097175;     // 25 * TEMP_BIAS_Q
    localparam logic [23:0] RECIP_25      = 24'd10737419;    // ceil(2^28 / 25)
    localparam int          RECIP_SHIFT   = 28;

endpackage

`default_nettype wire

>>> rtl/imu_serial_frame_parser.sv
`default_nettype none

// Serial IMU frame parser. Feed the received UART bytes one per transfer on
// the s_axis side; the parser hunts for the header byte, takes a kind byte
// (0x50 or above), eight data bytes forming four little-endian signed 16-bit
// words and a checksum byte (8-bit wrapping sum of header, kind and data).
// A frame with a good checksum and a kind matching one of the kind registers
// yields one result transfer on m_axis: tuser carries the kind (0 gyro,
// 1 accel, 2 euler, 3 magnetometer) and tdata the three axis values and the
// temperature, all fixed point with 8 fraction bits. Bad frames are dropped
// silently. One byte is taken every clock cycle while s_axis_tready is high;
// after its checksum byte a result moves through the frame, scaling (with
// the temperature reciprocal multiplier) and output registers. Each stage
// advances whenever the stage after it is empty or draining, so gaps close
// up while m_axis_tready is low, and s_axis_tready drops only once all
// three hold a result. Configuration writes are always ready and take
// effect on the next byte; write them only while no frame is in flight.
module imu_serial_frame_parser
    import isfp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // [7:0] rx_byte

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [23:0] axis_x, [47:24] axis_y, [71:48] axis_z, [89:72] temperature,
    // [95:90] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic [1:0]                  m_axis_tuser,   // [1:0] frame_kind

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [7:0]             cfg_data
);

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_KIND,
        PH_DATA,
        PH_CHECK
    } phase_t;

    // Configuration registers
    logic [7:0] header_reg, accel_reg, gyro_reg, euler_reg, mag_reg;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [2:0]  count_reg, count_next;
    logic [7:0]  code_reg, code_next;
    logic [63:0] data_reg, data_next;

    // Frame stage: one checked frame waiting for scaling
    logic        frm_valid_reg;
    kind_t       frm_kind_reg;
    logic [63:0] frm_data_reg;

    // Scaling stage
    logic                     calc_valid_reg;
    kind_t                    calc_kind_reg;
    logic signed [AXIS_W-1:0] calc_axis_reg [3];
    logic [17:0]              calc_quot_reg;

    // Output register
    logic                     out_valid_reg;
    kind_t                    out_kind_reg;
    logic signed [AXIS_W-1:0] out_axis_reg [3];
    logic signed [TEMP_W-1:0] out_temp_reg;

    logic  in_xfer;
    logic  out_free, calc_free, frm_free;
    logic  frame_good;
    kind_t frame_kind;
    logic  kind_known;

    // Pipeline flow: a stage loads when it is empty or drains this cycle
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign calc_free = !calc_valid_reg || out_free;
    assign frm_free  = !frm_valid_reg || calc_free;

    assign s_axis_tready = frm_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Kind lookup, gyro first when registers are equal
    always_comb
    begin
        kind_known = 1'b1;
        frame_kind = KIND_GYRO;
        if (code_reg == gyro_reg)
            frame_kind = KIND_GYRO;
        else if (code_reg == accel_reg)
            frame_kind = KIND_ACCEL;
        else if (code_reg == euler_reg)
            frame_kind = KIND_EULER;
        else if (code_reg == mag_reg)
            frame_kind = KIND_MAG;
        else
            kind_known = 1'b0;
    end

    // Byte parser
    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        code_next  = code_reg;
        data_next  = data_reg;
        frame_good = 1'b0;
        unique case (phase_reg)
            PH_HEAD:
            begin
                sum_next   = 8'd0;
                count_next = 3'd0;
                if (s_axis_tdata == header_reg)
                begin
                    sum_next   = s_axis_tdata;
                    phase_next = PH_KIND;
                end
            end
            PH_KIND:
            begin
                if (s_axis_tdata >= KIND_MIN)
                begin
                    code_next  = s_axis_tdata;
                    sum_next   = sum_reg + s_axis_tdata;
                    phase_next = PH_DATA;
                end
                else
                begin
                    phase_next = PH_HEAD;
                end
            end
            PH_DATA:
            begin
                // every data byte position is written before the checksum
                sum_next = sum_reg + s_axis_tdata;
                data_next[{count_reg, 3'b000} +: 8] = s_axis_tdata;
                count_next = count_reg + 3'd1;
                if (count_reg == 3'd7)
                    phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                phase_next = PH_HEAD;
                frame_good = (s_axis_tdata == sum_reg) && kind_known;
            end
            default:
            begin
                phase_next = PH_HEAD;
            end
        endcase
    end

    // Scaling of the three axis words and the temperature dividend
    logic signed [AXIS_W-1:0] axis_scaled [3];
    logic [45:0]              temp_prod;
    logic signed [21:0]       temp_dividend;
    logic [21:0]              temp_biased;

    always_comb
    begin
        logic signed [15:0]       w;
        logic signed [AXIS_W-1:0] wx;
        logic signed [AXIS_W-1:0] prod;
        for (int i = 0; i < 3; i++)
        begin
            w  = frm_data_reg[16*i +: 16];
            wx = AXIS_W'(w);
            prod = '0;
            case (frm_kind_reg)
                KIND_GYRO:
                begin
                    prod = wx * 24'sd125;
                    axis_scaled[i] = prod >>> 3;
                end
                KIND_ACCEL: axis_scaled[i] = wx >>> 3;
                KIND_EULER:
                begin
                    prod = wx * 24'sd45;
                    axis_scaled[i] = prod >>> 5;
                end
                default:    axis_scaled[i] = {w, 8'h00};
            endcase
        end
    end

    // the biased dividend always lands in [0, 2^22), so 22 bits hold it
    assign temp_dividend = {frm_data_reg[63:48], 6'b000000};
    assign temp_biased   = temp_dividend + TEMP_BIAS[21:0];
    assign temp_prod     = temp_biased * RECIP_25;

    // Configuration and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RST;
            accel_reg  <= ACCEL_RST;
            gyro_reg   <= GYRO_RST;
            euler_reg  <= EULER_RST;
            mag_reg    <= MAG_RST;
            phase_reg  <= PH_HEAD;
            sum_reg    <= 8'd0;
            count_reg  <= 3'd0;
            code_reg   <= 8'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_HEADER: header_reg <= cfg_data;
                    REG_ACCEL:  accel_reg  <= cfg_data;
                    REG_GYRO:   gyro_reg   <= cfg_data;
                    REG_EULER:  euler_reg  <= cfg_data;
                    REG_MAG:    mag_reg    <= cfg_data;
                    default:    ;
                endcase
            end
            if (in_xfer)
            begin
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
                count_reg <= count_next;
                code_reg  <= code_next;
            end
        end
    end

    // Payload word buffer, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            data_reg <= data_next;
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frm_valid_reg  <= 1'b0;
            calc_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (frm_free)
                frm_valid_reg <= in_xfer && frame_good;
            if (calc_free)
                calc_valid_reg <= frm_valid_reg;
            if (out_free)
                out_valid_reg <= calc_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (frm_free && in_xfer && frame_good)
        begin
            frm_kind_reg <= frame_kind;
            frm_data_reg <= data_reg;
        end
        if (calc_free && frm_valid_reg)
        begin
            calc_kind_reg <= frm_kind_reg;
            calc_axis_reg <= axis_scaled;
            calc_quot_reg <= temp_prod[45:RECIP_SHIFT];
        end
        if (out_free && calc_valid_reg)
        begin
            out_kind_reg <= calc_kind_reg;
            out_axis_reg <= calc_axis_reg;
            // drop the bias; temperature is zero for all but magnetometer
            if (calc_kind_reg == KIND_MAG)
                out_temp_reg <= calc_quot_reg - TEMP_BIAS_Q;
            else
                out_temp_reg <= '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {6'b000000, out_temp_reg, out_axis_reg[2],
                            out_axis_reg[1], out_axis_reg[0]};

endmodule

`default_nettype wire

>>> rtl/isfp_checker.sv
`default_nettype none

module isfp_checker
    import isfp_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [1:0]             m_axis_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Input is refused only while a result waits on a stalled output
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused with output free");

    // Temperature only on magnetometer frames
    a_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_MAG |-> m_axis_tdata[89:72] == '0)
        else $error("temperature set on non-magnetometer frame");

    // Padding stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[95:90] == '0)
        else $error("tdata padding not zero");

    // Accel values come from a 16-bit word shifted down by three
    a_accel_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ACCEL |->
            (m_axis_tdata[23:12] == '0 || m_axis_tdata[23:12] == '1))
        else $error("accel axis_x out of range");

endmodule

bind imu_serial_frame_parser isfp_checker u_isfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
